// ----- rtl/per_queue_traffic_statistics_defines.svh -----
// ----------------------------------------------------------------------------
// per_queue_traffic_statistics_defines
// assertion macros used by the checker file of the statistics block
// ----------------------------------------------------------------------------
`ifndef PER_QUEUE_TRAFFIC_STATISTICS_DEFINES_SVH
`define PER_QUEUE_TRAFFIC_STATISTICS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PQTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqts assertion failed");

// next-cycle implication, disabled during reset
`define PQTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqts assertion failed");

`endif

// ----- rtl/pqts_pkg.sv -----
// ----------------------------------------------------------------------------
// pqts_pkg
// types, sizes and opcodes of the per-queue traffic statistics block
// ----------------------------------------------------------------------------
package pqts_pkg;

   localparam int NUM_QUEUES = 64;
   localparam int NUM_VFS    = 16;

   localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int VAW = (NUM_VFS > 1) ? $clog2(NUM_VFS) : 1;

   localparam logic [3:0] OP_QTX      = 4'd0;
   localparam logic [3:0] OP_QRX      = 4'd1;
   localparam logic [3:0] OP_QERR     = 4'd2;
   localparam logic [3:0] OP_VFTX     = 4'd3;
   localparam logic [3:0] OP_VFRX     = 4'd4;
   localparam logic [3:0] OP_MAILBOX  = 4'd5;
   localparam logic [3:0] OP_READQ    = 4'd6;
   localparam logic [3:0] OP_READVF   = 4'd7;
   localparam logic [3:0] OP_READPORT = 4'd8;
   localparam logic [3:0] OP_CLRQ     = 4'd9;
   localparam logic [3:0] OP_CLRVF    = 4'd10;
   localparam logic [3:0] OP_CLRALL   = 4'd11;

   localparam logic [2:0] ERR_TX_LAST = 3'd2;
   localparam logic [2:0] ERR_RX_LAST = 3'd6;

   typedef struct packed {
      logic [2:0]  pad;
      logic [2:0]  error_kind;
      logic [15:0] byte_count;
      logic [5:0]  entity_id;
      logic [3:0]  opcode;
   } req_type;

   typedef struct packed {
      logic [63:0] mailbox_total;
      logic [63:0] rx_error_total;
      logic [63:0] rx_packet_total;
      logic [63:0] rx_byte_total;
      logic [63:0] tx_error_total;
      logic [63:0] tx_packet_total;
      logic [63:0] tx_byte_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] rx_err_cnt;
      logic [63:0] rx_pkt_cnt;
      logic [63:0] rx_byte_cnt;
      logic [63:0] tx_err_cnt;
      logic [63:0] tx_pkt_cnt;
      logic [63:0] tx_byte_cnt;
   } q_row_type;

   typedef struct packed {
      logic [63:0] mailbox;
      logic [63:0] rx_pkt_cnt;
      logic [63:0] rx_byte_cnt;
      logic [63:0] tx_pkt_cnt;
      logic [63:0] tx_byte_cnt;
   } vf_row_type;

   typedef struct packed {
      logic accept;
      logic commit;
      logic load_item;
      logic sweep_rd;
      logic acc_add;
      logic load_port;
   } cmd_type;

   typedef struct packed {
      logic req_port_read;
      logic item_read;
      logic cnt_zero;
      logic cnt_last;
      logic rsp_busy;
   } status_type;

endpackage

// ----- rtl/pqts_ram.sv -----
// ----------------------------------------------------------------------------
// pqts_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module pqts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pqts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pqts_ctrl
// sequencer: item accept, update commit, port-total sweep, result hand-off
// ----------------------------------------------------------------------------
module pqts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output pqts_pkg::cmd_type   cmd,
   input  pqts_pkg::status_type status
);
   import pqts_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_SWEEP    = 3'd2;
   localparam logic [2:0] S_DRAIN    = 3'd3;
   localparam logic [2:0] S_PORT_OUT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_port_read ? S_SWEEP : S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
            if (!status.item_read) begin
               state_in = S_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.load_item = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SWEEP: begin
            // row of the previous address lands while the next one is read
            cmd.sweep_rd = 1'b1;
            cmd.acc_add  = !status.cnt_zero;
            if (status.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.acc_add = 1'b1;
            state_in    = S_PORT_OUT;
         end
         S_PORT_OUT: begin
            if (!status.rsp_busy) begin
               cmd.load_port = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/pqts_datapath.sv -----
// ----------------------------------------------------------------------------
// pqts_datapath
// counter tables, valid bits, update adders, port-total accumulator, result
// register
// ----------------------------------------------------------------------------
module pqts_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          req_tdata,
   input  pqts_pkg::cmd_type    cmd,
   output pqts_pkg::status_type status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [447:0]         rsp_tdata
);
   import pqts_pkg::*;

   req_type    req;
   logic [3:0] op_ff;
   logic [5:0] id_ff;
   logic [15:0] len_ff;
   logic [2:0] kind_ff;
   logic       q_ok_ff;
   logic       v_ok_ff;

   logic [NUM_QUEUES-1:0] qvalid_ff;
   logic [NUM_VFS-1:0]    vvalid_ff;
   logic                  qhit_ff;
   logic                  vhit_ff;
   logic [QAW-1:0]        cnt_ff;
   q_row_type             acc_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                        q_rd_en;
   logic [QAW-1:0]              q_rd_addr;
   logic [QAW-1:0]              q_addr;
   logic [$bits(q_row_type)-1:0] q_rd_data;
   logic                        q_wr_en;
   q_row_type                   q_row;
   q_row_type                   q_next;

   logic                         v_rd_en;
   logic [VAW-1:0]               v_rd_addr;
   logic [VAW-1:0]               v_addr;
   logic [$bits(vf_row_type)-1:0] v_rd_data;
   logic                         v_wr_en;
   vf_row_type                   v_row;
   vf_row_type                   v_next;

   rsp_type item_rsp;

   assign req = req_type'(req_tdata);

   assign q_rd_en   = cmd.accept | cmd.sweep_rd;
   assign q_rd_addr = cmd.accept ? QAW'(req.entity_id) : cnt_ff;
   assign q_addr    = QAW'(id_ff);
   assign v_rd_en   = cmd.accept;
   assign v_rd_addr = VAW'(req.entity_id);
   assign v_addr    = VAW'(id_ff);

   // an entry whose valid bit is clear reads as all zero
   assign q_row = qhit_ff ? q_row_type'(q_rd_data) : '0;
   assign v_row = vhit_ff ? vf_row_type'(v_rd_data) : '0;

   always_comb begin
      q_next = q_row;
      case (op_ff)
         OP_QTX: begin
            q_next.tx_pkt_cnt  = q_row.tx_pkt_cnt + 64'd1;
            q_next.tx_byte_cnt = q_row.tx_byte_cnt + 64'(len_ff);
         end
         OP_QRX: begin
            q_next.rx_pkt_cnt  = q_row.rx_pkt_cnt + 64'd1;
            q_next.rx_byte_cnt = q_row.rx_byte_cnt + 64'(len_ff);
         end
         OP_QERR: begin
            if (kind_ff <= ERR_TX_LAST) begin
               q_next.tx_err_cnt = q_row.tx_err_cnt + 64'd1;
            end else if (kind_ff <= ERR_RX_LAST) begin
               q_next.rx_err_cnt = q_row.rx_err_cnt + 64'd1;
            end
         end
         default: begin
            q_next = q_row;
         end
      endcase
   end

   always_comb begin
      v_next = v_row;
      case (op_ff)
         OP_VFTX: begin
            v_next.tx_pkt_cnt  = v_row.tx_pkt_cnt + 64'd1;
            v_next.tx_byte_cnt = v_row.tx_byte_cnt + 64'(len_ff);
         end
         OP_VFRX: begin
            v_next.rx_pkt_cnt  = v_row.rx_pkt_cnt + 64'd1;
            v_next.rx_byte_cnt = v_row.rx_byte_cnt + 64'(len_ff);
         end
         OP_MAILBOX: begin
            v_next.mailbox = v_row.mailbox + 64'd1;
         end
         default: begin
            v_next = v_row;
         end
      endcase
   end

   assign q_wr_en = cmd.commit && q_ok_ff &&
                    (op_ff == OP_QTX || op_ff == OP_QRX || op_ff == OP_QERR);
   assign v_wr_en = cmd.commit && v_ok_ff &&
                    (op_ff == OP_VFTX || op_ff == OP_VFRX || op_ff == OP_MAILBOX);

   pqts_ram #(.WIDTH($bits(q_row_type)), .DEPTH(NUM_QUEUES)) u_qram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_addr),
      .wr_data (q_next),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   pqts_ram #(.WIDTH($bits(vf_row_type)), .DEPTH(NUM_VFS)) u_vram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_addr),
      .wr_data (v_next),
      .rd_en   (v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   always_comb begin
      item_rsp = '0;
      if (op_ff == OP_READQ) begin
         if (q_ok_ff) begin
            item_rsp.tx_byte_total   = q_row.tx_byte_cnt;
            item_rsp.tx_packet_total = q_row.tx_pkt_cnt;
            item_rsp.tx_error_total  = q_row.tx_err_cnt;
            item_rsp.rx_byte_total   = q_row.rx_byte_cnt;
            item_rsp.rx_packet_total = q_row.rx_pkt_cnt;
            item_rsp.rx_error_total  = q_row.rx_err_cnt;
         end
      end else if (v_ok_ff) begin
         item_rsp.tx_byte_total   = v_row.tx_byte_cnt;
         item_rsp.tx_packet_total = v_row.tx_pkt_cnt;
         item_rsp.rx_byte_total   = v_row.rx_byte_cnt;
         item_rsp.rx_packet_total = v_row.rx_pkt_cnt;
         item_rsp.mailbox_total   = v_row.mailbox;
      end
   end

   // item registers, sweep counter, accumulator, result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req.opcode;
         id_ff   <= req.entity_id;
         len_ff  <= req.byte_count;
         kind_ff <= req.error_kind;
         q_ok_ff <= 32'(req.entity_id) < NUM_QUEUES;
         v_ok_ff <= 32'(req.entity_id) < NUM_VFS;
      end
      if (q_rd_en) begin
         qhit_ff <= qvalid_ff[q_rd_addr];
      end
      if (v_rd_en) begin
         vhit_ff <= vvalid_ff[v_rd_addr];
      end
      if (cmd.accept) begin
         cnt_ff <= '0;
      end else if (cmd.sweep_rd) begin
         cnt_ff <= cnt_ff + QAW'(1);
      end
      if (cmd.accept) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff.tx_byte_cnt <= acc_ff.tx_byte_cnt + q_row.tx_byte_cnt;
         acc_ff.tx_pkt_cnt  <= acc_ff.tx_pkt_cnt + q_row.tx_pkt_cnt;
         acc_ff.tx_err_cnt  <= acc_ff.tx_err_cnt + q_row.tx_err_cnt;
         acc_ff.rx_byte_cnt <= acc_ff.rx_byte_cnt + q_row.rx_byte_cnt;
         acc_ff.rx_pkt_cnt  <= acc_ff.rx_pkt_cnt + q_row.rx_pkt_cnt;
         acc_ff.rx_err_cnt  <= acc_ff.rx_err_cnt + q_row.rx_err_cnt;
      end
      if (cmd.load_item) begin
         rsp_ff <= item_rsp;
      end else if (cmd.load_port) begin
         rsp_ff.mailbox_total   <= '0;
         rsp_ff.tx_byte_total   <= acc_ff.tx_byte_cnt;
         rsp_ff.tx_packet_total <= acc_ff.tx_pkt_cnt;
         rsp_ff.tx_error_total  <= acc_ff.tx_err_cnt;
         rsp_ff.rx_byte_total   <= acc_ff.rx_byte_cnt;
         rsp_ff.rx_packet_total <= acc_ff.rx_pkt_cnt;
         rsp_ff.rx_error_total  <= acc_ff.rx_err_cnt;
      end
   end

   // valid bits stand in for the zeroed tables after reset and clears
   always_ff @(posedge clock) begin
      if (reset) begin
         qvalid_ff    <= '0;
         vvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (op_ff == OP_CLRALL) begin
               qvalid_ff <= '0;
               vvalid_ff <= '0;
            end else if (op_ff == OP_CLRQ && q_ok_ff) begin
               qvalid_ff[q_addr] <= 1'b0;
            end else if (op_ff == OP_CLRVF && v_ok_ff) begin
               vvalid_ff[v_addr] <= 1'b0;
            end else if (q_wr_en) begin
               qvalid_ff[q_addr] <= 1'b1;
            end else if (v_wr_en) begin
               vvalid_ff[v_addr] <= 1'b1;
            end
         end
         if (cmd.load_item || cmd.load_port) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.req_port_read = req.opcode == OP_READPORT;
   assign status.item_read     = op_ff == OP_READQ || op_ff == OP_READVF;
   assign status.cnt_zero      = cnt_ff == '0;
   assign status.cnt_last      = 32'(cnt_ff) == NUM_QUEUES - 1;
   assign status.rsp_busy      = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ----- rtl/per_queue_traffic_statistics.sv -----
// update, clear and unknown items: accept, then commit, no result
// queue and virtual function reads: accept, then the result is loaded once the output register is free
// port totals: sweep, drain and port-out states, one queue row read per cycle from the queue RAM
// the next item is taken while a result waits in the output register
// reset (synchronous) clears the table valid bits, no clearing pass
// ----------------------------------------------------------------------------
// per_queue_traffic_statistics
// per-queue and per-virtual-function traffic counters with read-back
// ----------------------------------------------------------------------------
module per_queue_traffic_statistics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, entity_id, byte_count, error_kind, zero pad
   input  logic [31:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tx_byte_total, tx_packet_total, tx_error_total, rx_byte_total,
   // rx_packet_total, rx_error_total, mailbox_total
   output logic [447:0] rsp_tdata
);
   import pqts_pkg::*;

   cmd_type    cmd;
   status_type status;

   pqts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pqts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/pqts_checker.sv -----
// ----------------------------------------------------------------------------
// pqts_checker
// port-level checks of the statistics block, bound to the top level
// ----------------------------------------------------------------------------
`include "per_queue_traffic_statistics_defines.svh"

module pqts_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [31:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [447:0] rsp_tdata
);
   import pqts_pkg::*;

   logic req_beat;
   logic upd_beat;

   assign req_beat = req_tvalid && req_tready;
   assign upd_beat = req_beat && req_tdata[3:0] <= OP_MAILBOX;

   // a result that is not taken holds its beat
   `PQTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the block never accepts two items back to back
   `PQTS_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_beat, !req_tready)

   // a new result is only loaded while the input side is closed
   `PQTS_ASSERT_IMPLY(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

   // counter updates never produce a result
   `PQTS_ASSERT_IMPLY(a_update_silent, clock, reset, $rose(rsp_tvalid), !$past(upd_beat, 2))

endmodule

bind per_queue_traffic_statistics pqts_checker u_pqts_checker (.*);
